// ===== hdl/hsr_pkg.sv =====
// ============================================================================
// hsr_pkg
// Shared widths, record type and order codes for the heap sort records core.
// ============================================================================
`default_nettype none

package hsr_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_W    = 32;
    localparam int TAG_W    = 16;
    localparam int REC_W    = KEY_W + TAG_W;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = ADDR_W + 2;   // holds 2*node+2

    localparam logic ORDER_ASC  = 1'b0;     // max-heap, strict greater-than
    localparam logic ORDER_DESC = 1'b1;     // min-heap, strict less-than

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
    } t_rec;

    typedef struct packed {
        logic move;         // a child beats the held record
        logic sel_right;    // that child is the right one
    } t_pick;

endpackage

`default_nettype wire

// ===== hdl/hsr_ifs.sv =====
// ============================================================================
// hsr_ifs
// Valid/ready channels of the core: record input, result output, config.
// ============================================================================
`default_nettype none

interface hsr_rec_if import hsr_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [KEY_W-1:0] sort_key;
    logic [TAG_W-1:0]        record_tag;
    logic                    set_end;

    modport source (output valid, sort_key, record_tag, set_end, input ready);
    modport sink   (input valid, sort_key, record_tag, set_end, output ready);
endinterface

interface hsr_res_if import hsr_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [KEY_W-1:0] sorted_key;
    logic [TAG_W-1:0]        sorted_tag;
    logic                    final_item;
    logic                    dropped_any;

    modport source (output valid, sorted_key, sorted_tag, final_item, dropped_any,
                    input ready);
    modport sink   (input valid, sorted_key, sorted_tag, final_item, dropped_any,
                    output ready);
endinterface

interface hsr_cfg_if import hsr_pkg::*; ();
    logic valid;
    logic ready;
    logic sort_order;

    modport source (output valid, sort_order, input ready);
    modport sink   (input valid, sort_order, output ready);
endinterface

`default_nettype wire

// ===== hdl/hsr_ram.sv =====
// ============================================================================
// hsr_ram
// Generic RAM: one write port, two read ports, registered read data.
// ============================================================================
`default_nettype none

module hsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

// ===== hdl/hsr_pick.sv =====
// ============================================================================
// hsr_pick
// One sift level: does a child beat the held record, and which one.
// ============================================================================
`default_nettype none

module hsr_pick import hsr_pkg::*; (
    input  wire logic  i_order,
    input  wire t_rec  i_hold,
    input  wire t_rec  i_left,
    input  wire t_rec  i_right,
    input  wire logic  i_left_ok,
    input  wire logic  i_right_ok,
    output t_pick      o_pick
);

    logic                    w_left_wins;
    logic                    w_right_wins;
    logic signed [KEY_W-1:0] w_best_key;

    // strict compare: ties keep the earlier candidate (parent, then left)
    always_comb begin
        if (i_order == ORDER_DESC) begin
            w_left_wins = i_left_ok && (i_left.key < i_hold.key);
        end else begin
            w_left_wins = i_left_ok && (i_left.key > i_hold.key);
        end
        w_best_key = w_left_wins ? i_left.key : i_hold.key;
        if (i_order == ORDER_DESC) begin
            w_right_wins = i_right_ok && (i_right.key < w_best_key);
        end else begin
            w_right_wins = i_right_ok && (i_right.key > w_best_key);
        end
        o_pick.move      = w_left_wins || w_right_wins;
        o_pick.sel_right = w_right_wins;
    end

endmodule

`default_nettype wire

// ===== hdl/heap_sort_records_core.sv =====
// ============================================================================
// heap_sort_records_core
// Loads a set of records, heapsorts them in place in a RAM, emits them.
// ============================================================================
//
//  channel  dir  beat payload                                   handshake
//  -------  ---  ---------------------------------------------  ---------
//  i_rec    in   sort_key[31:0] record_tag[15:0] set_end        valid/ready
//  o_res    out  sorted_key sorted_tag final_item dropped_any   valid/ready
//  i_cfg    in   sort_order (0 ascending, 1 descending)         valid/ready
//
//  Loading accepts a record beat whenever i_rec.valid is high. After the set_end beat the
//  core sorts in the RAM: a sift level reads both children (SIFT_RD), then compares and
//  writes back (SIFT_CMP); each build node adds BLD_START and BLD_HOLD, each extract step
//  EXT_START and EXT_SWAP. Emit then walks EMIT_RD, EMIT_LD and EMIT_WAIT per result beat.
//  Reset (synchronous, active low) clears count, overflow, order and output valid.
//  i_rec.ready is low from set_end until the final result beat; o_res stalls hold.
// ============================================================================
`default_nettype none

module heap_sort_records_core import hsr_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    hsr_rec_if.sink   i_rec,
    hsr_res_if.source o_res,
    hsr_cfg_if.sink   i_cfg
);

    typedef enum logic [3:0] {
        S_LOAD,
        S_BLD_START,
        S_BLD_HOLD,
        S_SIFT_RD,
        S_SIFT_CMP,
        S_EXT_START,
        S_EXT_SWAP,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_WAIT
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;        // records held in this set
    logic             r_ovf;        // a record of this set was dropped
    logic             r_order;
    logic [CNT_W-1:0] r_n;          // set size frozen at set_end
    logic [CNT_W-1:0] r_i;          // build loop: next node is r_i-1
    logic [CNT_W-1:0] r_m;          // extract loop: current heap size
    logic [CNT_W-1:0] r_size;       // heap size of the running sift
    logic [ADDR_W-1:0] r_node;      // slot the held record may take
    logic             r_build;      // sift belongs to the build phase
    logic [CNT_W-1:0] r_k;          // emit index
    t_rec             r_hold;       // record being sifted down

    t_rec             r_out;
    logic             r_out_valid;
    logic             r_out_final;
    logic             r_out_drop;

    // RAM ports
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    t_rec              w_wdata;
    logic [ADDR_W-1:0] w_raddr_a;
    logic [ADDR_W-1:0] w_raddr_b;
    logic [REC_W-1:0]  w_rdata_a;
    logic [REC_W-1:0]  w_rdata_b;
    t_rec              w_rec_a;
    t_rec              w_rec_b;

    logic [IDX_W-1:0]  w_left;
    logic [IDX_W-1:0]  w_right;
    logic              w_left_ok;
    logic              w_right_ok;
    t_pick             w_pick;
    logic              w_in_beat;
    logic              w_has_room;
    logic [CNT_W-1:0]  w_n_new;
    logic [ADDR_W-1:0] w_m_last;
    logic              w_last_emit;

    assign w_rec_a    = t_rec'(w_rdata_a);
    assign w_rec_b    = t_rec'(w_rdata_b);

    // children of the current slot, checked against the live heap size
    assign w_left     = {1'b0, r_node, 1'b1};
    assign w_right    = w_left + IDX_W'(1);
    assign w_left_ok  = w_left  < IDX_W'(r_size);
    assign w_right_ok = w_right < IDX_W'(r_size);

    assign w_in_beat  = i_rec.valid && i_rec.ready;
    assign w_has_room = r_cnt < CNT_W'(CAPACITY);
    assign w_n_new    = w_has_room ? (r_cnt + CNT_W'(1)) : r_cnt;
    assign w_m_last   = ADDR_W'(r_m - CNT_W'(1));
    assign w_last_emit = (r_k + CNT_W'(1)) == r_n;

    assign i_rec.ready = (r_state == S_LOAD);
    assign i_cfg.ready = 1'b1;

    assign o_res.valid       = r_out_valid;
    assign o_res.sorted_key  = r_out.key;
    assign o_res.sorted_tag  = r_out.tag;
    assign o_res.final_item  = r_out_final;
    assign o_res.dropped_any = r_out_drop;

    hsr_pick u_pick (
        .i_order    (r_order),
        .i_hold     (r_hold),
        .i_left     (w_rec_a),
        .i_right    (w_rec_b),
        .i_left_ok  (w_left_ok),
        .i_right_ok (w_right_ok),
        .o_pick     (w_pick)
    );

    hsr_ram #(
        .WIDTH (REC_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    // RAM addressing per state; read data is used the cycle after
    always_comb begin
        w_we      = 1'b0;
        w_waddr   = r_node;
        w_wdata   = r_hold;
        w_raddr_a = '0;
        w_raddr_b = '0;
        unique case (r_state)
            S_LOAD: begin
                w_we          = w_in_beat && w_has_room;
                w_waddr       = r_cnt[ADDR_W-1:0];
                w_wdata.key   = i_rec.sort_key;
                w_wdata.tag   = i_rec.record_tag;
            end
            S_BLD_START: begin
                w_raddr_a = ADDR_W'(r_i - CNT_W'(1));
            end
            S_SIFT_RD: begin
                // no child: the held record settles here
                w_we      = !w_left_ok;
                w_raddr_a = w_left[ADDR_W-1:0];
                w_raddr_b = w_right[ADDR_W-1:0];
            end
            S_SIFT_CMP: begin
                w_we = 1'b1;
                if (w_pick.move) begin
                    w_wdata = w_pick.sel_right ? w_rec_b : w_rec_a;
                end
            end
            S_EXT_START: begin
                w_raddr_a = '0;
                w_raddr_b = w_m_last;
            end
            S_EXT_SWAP: begin
                // old root goes to the end of the shrinking heap
                w_we    = 1'b1;
                w_waddr = w_m_last;
                w_wdata = w_rec_a;
            end
            S_EMIT_RD: begin
                w_raddr_a = r_k[ADDR_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_order     <= ORDER_ASC;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_order <= i_cfg.sort_order;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (w_in_beat) begin
                        r_cnt <= w_n_new;
                        if (!w_has_room) begin
                            r_ovf <= 1'b1;
                        end
                        if (i_rec.set_end) begin
                            r_n     <= w_n_new;
                            r_i     <= w_n_new >> 1;
                            r_m     <= w_n_new;
                            r_state <= S_BLD_START;
                        end
                    end
                end
                S_BLD_START: begin
                    if (r_i == '0) begin
                        r_state <= S_EXT_START;
                    end else begin
                        r_node  <= ADDR_W'(r_i - CNT_W'(1));
                        r_size  <= r_n;
                        r_build <= 1'b1;
                        r_state <= S_BLD_HOLD;
                    end
                end
                S_BLD_HOLD: begin
                    r_hold  <= w_rec_a;
                    r_i     <= r_i - CNT_W'(1);
                    r_state <= S_SIFT_RD;
                end
                S_SIFT_RD: begin
                    if (w_left_ok) begin
                        r_state <= S_SIFT_CMP;
                    end else begin
                        r_state <= r_build ? S_BLD_START : S_EXT_START;
                    end
                end
                S_SIFT_CMP: begin
                    if (w_pick.move) begin
                        r_node  <= w_pick.sel_right ? w_right[ADDR_W-1:0]
                                                    : w_left[ADDR_W-1:0];
                        r_state <= S_SIFT_RD;
                    end else begin
                        r_state <= r_build ? S_BLD_START : S_EXT_START;
                    end
                end
                S_EXT_START: begin
                    if (r_m <= CNT_W'(1)) begin
                        r_k     <= '0;
                        r_state <= S_EMIT_RD;
                    end else begin
                        r_state <= S_EXT_SWAP;
                    end
                end
                S_EXT_SWAP: begin
                    r_hold  <= w_rec_b;
                    r_node  <= '0;
                    r_size  <= r_m - CNT_W'(1);
                    r_m     <= r_m - CNT_W'(1);
                    r_build <= 1'b0;
                    r_state <= S_SIFT_RD;
                end
                S_EMIT_RD: begin
                    r_state <= S_EMIT_LD;
                end
                S_EMIT_LD: begin
                    r_out       <= w_rec_a;
                    r_out_final <= w_last_emit;
                    r_out_drop  <= r_ovf;
                    r_out_valid <= 1'b1;
                    r_state     <= S_EMIT_WAIT;
                end
                S_EMIT_WAIT: begin
                    if (o_res.ready) begin
                        r_out_valid <= 1'b0;
                        if (r_out_final) begin
                            // set done: next beat opens a new set
                            r_cnt   <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= S_LOAD;
                        end else begin
                            r_k     <= r_k + CNT_W'(1);
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== test/heap_sort_records_core_tb.sv =====
// ----------------------------------------------------------------------------
// heap_sort_records_core_tb
// Self-checking bench for the heap sort records core. Record sets are loaded
// over the valid/ready input, a local heapsort of each set predicts the
// sorted beats, and every result beat is checked field by field in order.
// The run covers both sort orders, set sizes up to and past the store depth,
// and several sender/receiver idling mixes, including a long receiver hold.
// ----------------------------------------------------------------------------
module heap_sort_records_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hsr_pkg::*;

    localparam int IDLE_WATCH_LIMIT = 20000;  // cycles without any beat
    localparam int SETTLE_CYCLES    = 4;      // quiet cycles before an order write
    localparam int DRAIN_CYCLES     = 40;     // watch for stray beats at the end
    localparam int HOLD_CYCLES      = 2500;   // long receiver hold-off, outlasts a full sort
    localparam int N_ROWS           = 12;
    localparam int N_PHASES         = 8;

    // one expected result beat
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
        logic                    last_beat;
        logic                    dropped;
    } t_sorted;

    // directed stimulus row
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic             set_end;
        logic             self_sorted;  // one-record set: result is the record
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    hsr_rec_if rec_ch ();
    hsr_res_if res_ch ();
    hsr_cfg_if cfg_ch ();

    heap_sort_records_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rec   (rec_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // extremes, zero, sign flips, ties (tag order matters on ties)
    t_stim_row stim_rows [N_ROWS] = '{
        '{32'h7FFF_FFFF, 16'hFFFF, 1'b1, 1'b1},
        '{32'h8000_0000, 16'h0000, 1'b1, 1'b1},
        '{32'h0000_0000, 16'h5555, 1'b1, 1'b1},
        '{32'h0001_0000, 16'hAAAA, 1'b0, 1'b0},
        '{32'hFFFF_0000, 16'h0001, 1'b0, 1'b0},
        '{32'h0001_0000, 16'h0002, 1'b0, 1'b0},
        '{32'h8000_0000, 16'h8000, 1'b0, 1'b0},
        '{32'h7FFF_FFFF, 16'h7FFF, 1'b1, 1'b0},
        '{32'h0000_0005, 16'h0001, 1'b0, 1'b0},
        '{32'h0000_0005, 16'h0002, 1'b1, 1'b0},
        '{32'hFFFF_FFFF, 16'hFFFF, 1'b0, 1'b0},
        '{32'h0000_0001, 16'h0000, 1'b1, 1'b0}
    };

    // random phases: order, sender idle %, receiver stall %, item budget,
    // one leading set of the given size (0 for none), receiver hold-off
    logic phase_order   [N_PHASES] = '{ORDER_ASC, ORDER_DESC, ORDER_ASC, ORDER_DESC,
                                       ORDER_ASC, ORDER_DESC, ORDER_ASC, ORDER_DESC};
    int   phase_tx_idle [N_PHASES] = '{0, 65, 0, 38, 0, 65, 0, 38};
    int   phase_rx_stall[N_PHASES] = '{0, 0, 65, 38, 0, 0, 65, 38};
    int   phase_budget  [N_PHASES] = '{90, 35, 35, 75, 75, 35, 35, 40};
    int   phase_big_set [N_PHASES] = '{CAPACITY, 0, 0, CAPACITY + 1, CAPACITY + 3, 0, 0, 0};
    bit   phase_hold    [N_PHASES] = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};

    // predictor state
    t_rec    held_recs [CAPACITY];
    int      held_count    = 0;
    logic    held_overflow = 1'b0;
    logic    order_now     = ORDER_ASC;
    t_sorted fresh_results [$];

    t_sorted sorted_due [$];     // beats still owed by the core
    int      fail_count    = 0;
    int      tx_idle_pct   = 0;
    int      rx_stall_pct  = 0;
    int      hold_requests = 0;

    // ------------------------------------------------------------------------
    // clock and reset
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // predictor: in-place heapsort of the held set
    // ------------------------------------------------------------------------
    function automatic bit outranks(input int a, input int b);
        if (order_now == ORDER_DESC)
            return $signed(held_recs[a].key) < $signed(held_recs[b].key);
        return $signed(held_recs[a].key) > $signed(held_recs[b].key);
    endfunction

    function automatic void swap_recs(input int a, input int b);
        t_rec tmp;
        tmp          = held_recs[a];
        held_recs[a] = held_recs[b];
        held_recs[b] = tmp;
    endfunction

    // a child takes the parent's place only when strictly better; left wins ties
    function automatic void sift_down_recs(input int n, input int node);
        int best;
        int left_c;
        int right_c;
        while (1) begin
            best    = node;
            left_c  = 2 * node + 1;
            right_c = 2 * node + 2;
            if (left_c < n && outranks(left_c, best))
                best = left_c;
            if (right_c < n && outranks(right_c, best))
                best = right_c;
            if (best == node)
                return;
            swap_recs(node, best);
            node = best;
        end
    endfunction

    // store or drop one record; on set end, sort and queue the set's beats
    function automatic void take_record(input logic [KEY_W-1:0] key,
                                        input logic [TAG_W-1:0] tag,
                                        input logic set_end);
        t_sorted beat;
        int      i;
        if (held_count < CAPACITY) begin
            held_recs[held_count].key = key;
            held_recs[held_count].tag = tag;
            held_count++;
        end else begin
            held_overflow = 1'b1;   // store full, set_end record dropped too
        end
        if (!set_end)
            return;
        for (i = held_count / 2; i > 0; i--)
            sift_down_recs(held_count, i - 1);
        for (i = held_count; i > 1; i--) begin
            swap_recs(0, i - 1);
            sift_down_recs(i - 1, 0);
        end
        for (i = 0; i < held_count; i++) begin
            beat.key       = held_recs[i].key;
            beat.tag       = held_recs[i].tag;
            beat.last_beat = (i == held_count - 1);
            beat.dropped   = held_overflow;
            fresh_results.insert(fresh_results.size(), beat);
        end
        held_count    = 0;
        held_overflow = 1'b0;
    endfunction

    // ------------------------------------------------------------------------
    // record sender
    // ------------------------------------------------------------------------
    // Leaves valid high after the beat; the next call either replaces the
    // payload in the same step or idles, and park_sender lowers it.
    task automatic offer_record(input logic [KEY_W-1:0] key, input logic [TAG_W-1:0] tag,
                                input logic set_end, input logic self_sorted);
        t_sorted own;
        while ($urandom_range(99) < tx_idle_pct) begin
            rec_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        rec_ch.valid      <= 1'b1;
        rec_ch.sort_key   <= key;
        rec_ch.record_tag <= tag;
        rec_ch.set_end    <= set_end;
        do @(posedge i_clk); while (!rec_ch.ready);
        take_record(key, tag, set_end);
        if (self_sorted) begin
            fresh_results.delete();
            own.key       = key;
            own.tag       = tag;
            own.last_beat = 1'b1;
            own.dropped   = 1'b0;
            sorted_due.insert(sorted_due.size(), own);
        end else begin
            while (fresh_results.size() != 0)
                sorted_due.insert(sorted_due.size(), fresh_results.pop_front());
        end
    endtask

    task automatic park_sender();
        rec_ch.valid <= 1'b0;
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(9)) inside
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            [2:4]:   return 32'($urandom_range(6)) - 32'd3;   // tie-prone, both signs
            default: return $urandom();
        endcase
    endfunction

    task automatic send_set(input int n);
        int k;
        for (k = 0; k < n; k++)
            offer_record(pick_key(), 16'($urandom_range(16'hFFFF)), k == n - 1, 1'b0);
    endtask

    // order register: only with no set pending and no beats owed
    task automatic write_order(input logic value);
        while (sorted_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.sort_order <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        order_now = value;
        cfg_ch.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // result receiver: random stalls plus an occasional long hold-off
    // ------------------------------------------------------------------------
    initial begin
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // checker
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t ns %s: expected %h, got %h", $realtime, field, want, got);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_sorted want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (sorted_due.size() == 0) begin
                report_mismatch("result beat with nothing owed, key", 32'h0,
                                res_ch.sorted_key);
            end else begin
                want = sorted_due.pop_front();
                if (res_ch.sorted_key !== want.key)
                    report_mismatch("sorted_key", want.key, res_ch.sorted_key);
                if (res_ch.sorted_tag !== want.tag)
                    report_mismatch("sorted_tag", 32'(want.tag), 32'(res_ch.sorted_tag));
                if (res_ch.final_item !== want.last_beat)
                    report_mismatch("final_item", 32'(want.last_beat),
                                    32'(res_ch.final_item));
                if (res_ch.dropped_any !== want.dropped)
                    report_mismatch("dropped_any", 32'(want.dropped),
                                    32'(res_ch.dropped_any));
            end
        end
    end

    // watchdog: a run of cycles with no beat on any channel ends the test
    always @(posedge i_clk) begin
        int quiet_cycles;
        if ((rec_ch.valid && rec_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= IDLE_WATCH_LIMIT) begin
                $display("heap_sort_records_core: mismatch");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int r;
        int p;
        int sent;
        int n;
        i_rst_n           <= 1'b0;
        rec_ch.valid      <= 1'b0;
        rec_ch.sort_key   <= '0;
        rec_ch.record_tag <= '0;
        rec_ch.set_end    <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.sort_order <= ORDER_ASC;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows, once per order
        write_order(ORDER_ASC);
        for (r = 0; r < N_ROWS; r++)
            offer_record(stim_rows[r].key, stim_rows[r].tag, stim_rows[r].set_end,
                         stim_rows[r].self_sorted);
        park_sender();
        write_order(ORDER_DESC);
        for (r = 0; r < N_ROWS; r++)
            offer_record(stim_rows[r].key, stim_rows[r].tag, stim_rows[r].set_end,
                         stim_rows[r].self_sorted);
        park_sender();

        // random sets, phase by phase
        for (p = 0; p < N_PHASES; p++) begin
            write_order(phase_order[p]);
            tx_idle_pct  = phase_tx_idle[p];
            rx_stall_pct = phase_rx_stall[p];
            sent = 0;
            if (phase_hold[p])
                hold_requests++;    // core fills up and stalls its input
            if (phase_big_set[p] != 0) begin
                send_set(phase_big_set[p]);
                sent += phase_big_set[p];
            end
            while (sent < phase_budget[p]) begin
                n = $urandom_range(1, 12);
                send_set(n);
                sent += n;
            end
            park_sender();
        end

        while (sorted_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && sorted_due.size() == 0)
            $display("heap_sort_records_core: match");
        else
            $display("heap_sort_records_core: mismatch");
        $finish;
    end

endmodule
